// File: hdl/smx_pkg.sv
// ---------------------------------------------------------------------------
// smx_pkg
// Shared types, widths and the exp table generator for the softmax block.
// ---------------------------------------------------------------------------
package smx_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int CNT_W       = 7;
    localparam int LOGIT_W     = 16;
    localparam int EXP_W       = 16;
    localparam int PROB_W      = 16;
    localparam int POS_W       = 6;
    localparam int SUM_W       = 22;
    localparam int QUO_W       = 17;
    localparam int DIV_STEP_W  = 5;

    // lookup offset of -10.0 in Q8.8
    localparam logic signed [16:0] EXP_FLOOR = -17'sd2560;
    // reciprocal of five in Q18, exact for the offsets used
    localparam logic [15:0] RECIP5 = 16'd52429;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic pass_clr;
        logic rd_clr;
        logic exp_rd;
        logic nrm_rd;
        logic div_start;
        logic out_load;
        logic run_clr;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic close;
        logic rd_end;
        logic exp_last;
        logic div_done;
        logic out_free;
        logic nrm_last;
    } t_sts;

    // exp(-t/16) in Q30 by series, squared four times, rounded to Q0.16
    function automatic logic [15:0] exp_from_u(input logic [63:0] u);
        longint      acc;
        logic [63:0] term;
        logic [63:0] v;
        logic [63:0] r;
        acc  = longint'(64'd1 << 30);
        term = 64'd1 << 30;
        for (int j = 1; j <= 20; j++) begin
            term = ((term * u) >> 30) / 64'(j);
            if ((j & 1) != 0) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(64'd1 << 30)) begin
            acc = longint'(64'd1 << 30);
        end
        v = 64'(acc);
        for (int k = 0; k < 4; k++) begin
            v = (v * v + (64'd1 << 29)) >> 30;
        end
        r = (v + (64'd1 << 13)) >> 14;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

endpackage

// File: hdl/smx_if.sv
// ---------------------------------------------------------------------------
// smx_in_if / smx_out_if
// Valid/ready channels for logit words in and probability words out.
// ---------------------------------------------------------------------------
interface smx_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [smx_pkg::LOGIT_W-1:0]     logit;
    logic                                   vector_end;

    modport source (output valid, output logit, output vector_end, input ready);
    modport sink   (input valid, input logit, input vector_end, output ready);
endinterface

interface smx_out_if;
    logic                           valid;
    logic                           ready;
    logic [smx_pkg::PROB_W-1:0]     probability;
    logic [smx_pkg::POS_W-1:0]      position;
    logic                           run_last;
    logic                           truncated;

    modport source (output valid, output probability, output position,
                    output run_last, output truncated, input ready);
    modport sink   (input valid, input probability, input position,
                    input run_last, input truncated, output ready);
endinterface

// File: hdl/softmax_exp_table_normalizer.sv
// ---------------------------------------------------------------------------
// softmax_exp_table_normalizer
// Softmax over vectors of Q8.8 logits with an exp lookup table.
// ---------------------------------------------------------------------------
// Usage:
//   i_in takes one logit word per cycle in load; vector_end ends the vector,
//   and the word that fills MAX_LEN entries closes it too, marked truncated.
//   o_out gives one probability word per element, in order, with position,
//   run_last on the final word and the truncation mark.
// Sequence:
//   load fills the logit store; the exp pass walks the logit store through
//   a 4-stage lookup pipe; normalize handles one word at a time: a store
//   read, a divider start and the bit-serial divider (17 steps).
//   No input is taken during the two passes; the next vector may load while
//   the last result still sits in the output register.
// Reset: synchronous, active low; clears the run (count, max) and all
//   valid flags. The stores need no clearing.
// Stall: a held output word blocks the next divide result; nothing is lost.
// ---------------------------------------------------------------------------
module softmax_exp_table_normalizer #(
    parameter int MAX_LEN   = 64,
    parameter int ROM_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smx_in_if.sink      i_in,
    smx_out_if.source   o_out
);

    smx_pkg::t_cmd cmd;
    smx_pkg::t_sts sts;

    // sequencer
    smx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    smx_dp #(
        .MAX_LEN   (MAX_LEN),
        .ROM_DEPTH (ROM_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_logit       (i_in.logit),
        .i_vector_end  (i_in.vector_end),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_probability (o_out.probability),
        .o_position    (o_out.position),
        .o_run_last    (o_out.run_last),
        .o_truncated   (o_out.truncated)
    );

endmodule

// File: hdl/smx_div.sv
// ---------------------------------------------------------------------------
// smx_div
// Restoring divider, one quotient bit a cycle: floor(e * 65536 / sum).
// ---------------------------------------------------------------------------
module smx_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [smx_pkg::EXP_W-1:0]   i_dividend,
    input  logic [smx_pkg::SUM_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [smx_pkg::PROB_W-1:0]  o_quotient
);

    logic [smx_pkg::SUM_W:0]        r_rem;
    logic [smx_pkg::QUO_W-1:0]      r_quo;
    logic [smx_pkg::DIV_STEP_W-1:0] r_step;
    logic                           r_busy;
    logic                           r_done;
    logic                           ge;
    logic [smx_pkg::SUM_W:0]        rem_sub;

    // one compare and subtract per step
    always_comb begin
        ge      = r_rem >= {1'b0, i_divisor};
        rem_sub = ge ? (r_rem - {1'b0, i_divisor}) : r_rem;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_step == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= (smx_pkg::SUM_W+1)'(i_dividend);
            r_quo  <= '0;
            r_step <= smx_pkg::DIV_STEP_W'(smx_pkg::QUO_W - 1);
        end else if (r_busy) begin
            r_rem  <= {rem_sub[smx_pkg::SUM_W-1:0], 1'b0};
            r_quo  <= {r_quo[smx_pkg::QUO_W-2:0], ge};
            r_step <= r_step - 1'b1;
        end
    end

    // saturate, and a zero divisor gives zero
    always_comb begin
        if (i_divisor == '0) begin
            o_quotient = '0;
        end else if (r_quo[smx_pkg::QUO_W-1]) begin
            o_quotient = '1;
        end else begin
            o_quotient = r_quo[smx_pkg::PROB_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// File: hdl/smx_dp.sv
// ---------------------------------------------------------------------------
// smx_dp
// Datapath: logit and exp stores, running max, exp lookup pipe, sum,
// divider and output register.
// ---------------------------------------------------------------------------
module smx_dp #(
    parameter int MAX_LEN   = 64,
    parameter int ROM_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  smx_pkg::t_cmd                       i_cmd,
    output smx_pkg::t_sts                       o_sts,
    input  logic signed [smx_pkg::LOGIT_W-1:0]  i_logit,
    input  logic                                i_vector_end,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [smx_pkg::PROB_W-1:0]          o_probability,
    output logic [smx_pkg::POS_W-1:0]           o_position,
    output logic                                o_run_last,
    output logic                                o_truncated
);

    localparam int IDX_W = $clog2(ROM_DEPTH);
    localparam logic [11:0] LUT_MAX = 12'(ROM_DEPTH - 1);
    localparam logic [11:0] IDX_CAP = 12'(ROM_DEPTH - 1);
    localparam logic [smx_pkg::CNT_W-1:0] MAX_CNT = smx_pkg::CNT_W'(MAX_LEN);

    // exp table, built at elaboration
    logic [smx_pkg::EXP_W-1:0] rom [ROM_DEPTH];

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        localparam longint N = 10 * (ROM_DEPTH - 1) - 20 * g;
        localparam logic [63:0] U = (N > 0) ? ((64'(N) << 26) / 64'(ROM_DEPTH - 1)) : 64'd0;
        assign rom[g] = (N > 0) ? smx_pkg::exp_from_u(U) : 16'hFFFF;
    end

    logic signed [smx_pkg::LOGIT_W-1:0] logit_mem [smx_pkg::STORE_DEPTH];
    logic [smx_pkg::EXP_W-1:0]          exp_mem   [smx_pkg::STORE_DEPTH];

    logic [smx_pkg::CNT_W-1:0]          r_cnt;
    logic signed [smx_pkg::LOGIT_W-1:0] r_max;
    logic                               r_cut;
    logic [smx_pkg::CNT_W-1:0]          r_ra;
    logic [smx_pkg::ADDR_W-1:0]         r_wa;
    logic [smx_pkg::SUM_W-1:0]          r_sum;

    logic                               r_v1, r_v2, r_v3, r_v4;
    logic signed [smx_pkg::LOGIT_W-1:0] r_lg1;
    logic [23:0]                        r_prod2;
    logic                               r_zero2, r_zero3, r_zero4;
    logic [IDX_W-1:0]                   r_idx3;
    logic [smx_pkg::EXP_W-1:0]          r_rom4;
    logic [smx_pkg::EXP_W-1:0]          r_exp_rd;

    logic                               r_out_valid;
    logic [smx_pkg::PROB_W-1:0]         r_prob;
    logic [smx_pkg::POS_W-1:0]          r_pos;
    logic                               r_last;
    logic                               r_trunc;

    logic [smx_pkg::CNT_W-1:0]          cnt_inc;
    logic [smx_pkg::CNT_W-1:0]          ra_inc;
    logic [smx_pkg::CNT_W-1:0]          cnt_dec;
    logic signed [16:0]                 diff;
    logic signed [16:0]                 off_full;
    logic [11:0]                        off;
    logic [29:0]                        recip_prod;
    logic [11:0]                        idx_full;
    logic [smx_pkg::EXP_W-1:0]          exp_val;
    logic                               div_done;
    logic [smx_pkg::PROB_W-1:0]         quotient;

    // status to the controller
    always_comb begin
        cnt_inc          = r_cnt + 1'b1;
        ra_inc           = r_ra + 1'b1;
        cnt_dec          = r_cnt - 1'b1;
        o_sts.close      = i_vector_end || (cnt_inc == MAX_CNT);
        o_sts.rd_end     = (r_ra == r_cnt);
        o_sts.exp_last   = r_v4 && ({1'b0, r_wa} == cnt_dec);
        o_sts.div_done   = div_done;
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.nrm_last   = (ra_inc == r_cnt);
    end

    // load: count, running max and truncation mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_max <= 16'sh8000;
        end else if (i_cmd.run_clr) begin
            r_cnt <= '0;
            r_max <= 16'sh8000;
        end else if (i_cmd.accept) begin
            r_cnt <= cnt_inc;
            if (i_logit > r_max) begin
                r_max <= i_logit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_sts.close) begin
            r_cut <= !i_vector_end;
        end
    end

    // logit store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            logit_mem[r_cnt[smx_pkg::ADDR_W-1:0]] <= i_logit;
        end
        if (i_cmd.exp_rd) begin
            r_lg1 <= logit_mem[r_ra[smx_pkg::ADDR_W-1:0]];
        end
    end

    // read pointer, shared by both passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra <= '0;
        end else if (i_cmd.pass_clr || i_cmd.rd_clr) begin
            r_ra <= '0;
        end else if (i_cmd.exp_rd || i_cmd.out_load) begin
            r_ra <= ra_inc;
        end
    end

    // lookup pipe valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.exp_rd;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // difference from the max, offset into the table range
    always_comb begin
        diff     = 17'(r_lg1) - 17'(r_max);
        off_full = diff - smx_pkg::EXP_FLOOR;
        off      = off_full[11:0];
    end

    // stage 2: scale the offset by the table size
    always_ff @(posedge i_clk) begin
        r_zero2 <= (diff <= smx_pkg::EXP_FLOOR);
        r_prod2 <= 24'(off) * 24'(LUT_MAX);
    end

    // stage 3: divide by 5120 as a shift and a reciprocal multiply
    always_comb begin
        recip_prod = 30'(r_prod2[23:10]) * 30'(smx_pkg::RECIP5);
        idx_full   = recip_prod[29:18];
    end

    always_ff @(posedge i_clk) begin
        r_zero3 <= r_zero2;
        r_idx3  <= (idx_full > IDX_CAP) ? IDX_CAP[IDX_W-1:0] : idx_full[IDX_W-1:0];
    end

    // stage 4: table read
    always_ff @(posedge i_clk) begin
        r_zero4 <= r_zero3;
        r_rom4  <= rom[r_idx3];
    end

    assign exp_val = r_zero4 ? '0 : r_rom4;

    // exp store and sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wa  <= '0;
            r_sum <= '0;
        end else if (i_cmd.pass_clr) begin
            r_wa  <= '0;
            r_sum <= '0;
        end else if (r_v4) begin
            r_wa  <= r_wa + 1'b1;
            r_sum <= r_sum + smx_pkg::SUM_W'(exp_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4) begin
            exp_mem[r_wa] <= exp_val;
        end
        if (i_cmd.nrm_rd) begin
            r_exp_rd <= exp_mem[r_ra[smx_pkg::ADDR_W-1:0]];
        end
    end

    // normalize
    smx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_exp_rd),
        .i_divisor  (r_sum),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_prob  <= quotient;
            r_pos   <= r_ra[smx_pkg::POS_W-1:0];
            r_last  <= o_sts.nrm_last;
            r_trunc <= r_cut;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_probability = r_prob;
    assign o_position    = r_pos;
    assign o_run_last    = r_last;
    assign o_truncated   = r_trunc;

endmodule

// File: hdl/smx_ctrl.sv
// ---------------------------------------------------------------------------
// smx_ctrl
// Sequencer: load, exp pass, then one divide per element of the vector.
// ---------------------------------------------------------------------------
module smx_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  smx_pkg::t_sts   i_sts,
    output smx_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_EXP   = 3'd1;
    localparam logic [2:0] S_NRD   = 3'd2;
    localparam logic [2:0] S_NDIV  = 3'd3;
    localparam logic [2:0] S_NWAIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_sts.close) begin
                    o_cmd.pass_clr = 1'b1;
                    n_state        = S_EXP;
                end
            end
            S_EXP: begin
                o_cmd.exp_rd = !i_sts.rd_end;
                if (i_sts.exp_last) begin
                    o_cmd.rd_clr = 1'b1;
                    n_state      = S_NRD;
                end
            end
            S_NRD: begin
                o_cmd.nrm_rd = 1'b1;
                n_state      = S_NDIV;
            end
            S_NDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_NWAIT;
            end
            S_NWAIT: begin
                if (i_sts.div_done && i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.nrm_last) begin
                        o_cmd.run_clr = 1'b1;
                        n_state       = S_LOAD;
                    end else begin
                        n_state = S_NRD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/smx_chk.sv
// ---------------------------------------------------------------------------
// smx_chk
// Port checks for the softmax block, bound to the top level.
// ---------------------------------------------------------------------------
module smx_chk #(
    parameter int MAX_LEN = 64
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [smx_pkg::PROB_W-1:0]   i_probability,
    input logic [smx_pkg::POS_W-1:0]    i_position,
    input logic                         i_run_last,
    input logic                         i_truncated
);

    localparam logic [smx_pkg::POS_W-1:0] LAST_POS = smx_pkg::POS_W'(MAX_LEN - 1);

    // a stalled word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its payload
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_probability) && $stable(i_position)
            && $stable(i_run_last) && $stable(i_truncated))
        else $error("output payload changed while stalled");

    // a cut vector ends exactly at the store limit
    a_cut_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_truncated && i_run_last |-> i_position == LAST_POS)
        else $error("truncated vector ended at wrong position");

    // nothing beyond the limit in a cut vector
    a_cut_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_truncated && !i_run_last |-> i_position < LAST_POS)
        else $error("truncated vector runs past the store limit");

    // no output word right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind softmax_exp_table_normalizer smx_chk #(.MAX_LEN(MAX_LEN)) u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_probability (o_out.probability),
    .i_position    (o_out.position),
    .i_run_last    (o_out.run_last),
    .i_truncated   (o_out.truncated)
);
